// ----- design/cbe_pkg.sv -----
// Package for the byte-offset encoder: shared widths, constants and the record type
// that carries one encoded pixel from the encoder to the serializer. No dependencies.
package cbe_pkg;

    localparam int PIXEL_W  = 32;
    localparam int FP_W     = 25;
    localparam int COUNT_W  = 27;
    localparam int NBYTES_W = 3;
    localparam int MAX_BYTES = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic signed [PIXEL_W-1:0] BYTE_LIMIT = 32'sd127;
    localparam logic signed [PIXEL_W-1:0] WORD_LIMIT = 32'sd32767;
    localparam logic [7:0]  ESC_BYTE = 8'h80;
    localparam logic [15:0] ESC_WORD = 16'h8000;

    localparam logic [NBYTES_W-1:0] LEN_SHORT = 3'd1;
    localparam logic [NBYTES_W-1:0] LEN_MID   = 3'd3;
    localparam logic [NBYTES_W-1:0] LEN_WIDE  = 3'd7;

    localparam logic [FP_W-1:0] FRAME_PIXELS_RST = 25'd1048576;

    localparam logic REG_FRAME_PIXELS = 1'b0;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [NBYTES_W-1:0]       nbytes;
        logic                      byte_valid;
        logic                      done;
        logic                      aborted;
        logic [COUNT_W-1:0]        base;
    } t_pixel_rec;

endpackage

// ----- design/cbf_byte_offset_encoder.sv -----
// Top level of the byte-offset encoder: configuration register, encoder and serializer.
// Depends on cbe_pkg, cbe_encoder and cbe_serializer.
//
// Usage: signed 32-bit pixels enter on the input channel (i_valid, o_stall, i_pixel)
// in raster order. Each pixel leaves as one to seven items on the output channel
// (o_valid, i_stall and the result fields), one encoded byte per item: one byte for a
// small difference, three for a 16-bit escape and seven for a 32-bit escape. Once a
// frame is aborted, each further pixel of that frame gives one empty item.
// The frame length is set through the APB register at address 0 while the block idles;
// the block does not enforce this, the user must. A pixel's first item passes through
// the record register and then the output register. One item per cycle goes out while
// the receiver does not stall, set by the single output register; a pixel with several
// items holds the input until its last item is taken, so short differences run at one
// pixel per cycle. A pixel is taken while the previous pixel's last item is being sent.
// Reset clears the frame state and the pending items and restores the default frame
// length; o_stall is high while reset is held. When the receiver stalls, the current
// item holds steady and o_stall rises once the pending pixel has nowhere to go.
module cbf_byte_offset_encoder
    import cbe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [PIXEL_W-1:0] i_pixel,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_last_of_pixel,
    output logic               o_frame_done,
    output logic               o_frame_aborted,
    output logic [COUNT_W-1:0] o_byte_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [FP_W-1:0] r_frame_pixels;
    logic            rec_free;
    logic            accept;
    t_pixel_rec      rec;

    assign pready  = 1'b1;
    assign o_stall = !rec_free || !i_rst_n;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FRAME_PIXELS_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_FRAME_PIXELS)) begin
            r_frame_pixels <= pwdata[FP_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_FRAME_PIXELS) begin
            prdata = APB_DW'(r_frame_pixels);
        end else begin
            prdata = '0;
        end
    end

    cbe_encoder u_encoder (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_pixel        (i_pixel),
        .i_frame_pixels (r_frame_pixels),
        .o_rec          (rec)
    );

    cbe_serializer u_serializer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept),
        .i_rec           (rec),
        .o_free          (rec_free),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last_of_pixel (o_last_of_pixel),
        .o_frame_done    (o_frame_done),
        .o_frame_aborted (o_frame_aborted),
        .o_byte_count    (o_byte_count)
    );

endmodule

// ----- design/cbe_encoder.sv -----
// Frame state and per-pixel encoding: builds the record of all bytes for one pixel.
// Depends on cbe_pkg.
module cbe_encoder
    import cbe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [PIXEL_W-1:0] i_pixel,
    input  logic [FP_W-1:0]    i_frame_pixels,
    output t_pixel_rec         o_rec
);

    logic [PIXEL_W-1:0] r_prev, n_prev;
    logic [FP_W-1:0]    r_cnt, n_cnt;
    logic [FP_W-1:0]    r_esc, n_esc;
    logic               r_abort, n_abort;
    logic [COUNT_W-1:0] r_total, n_total;

    logic [PIXEL_W-1:0]        diff;
    logic signed [PIXEL_W-1:0] sdiff;
    logic                      fits_byte;
    logic                      fits_word;
    logic [FP_W-1:0]           cnt_inc;
    logic [FP_W-1:0]           esc_inc;
    logic                      done;

    always_comb begin
        diff      = i_pixel - r_prev;
        sdiff     = $signed(diff);
        fits_byte = (sdiff >= -BYTE_LIMIT) && (sdiff <= BYTE_LIMIT);
        fits_word = (sdiff >= -WORD_LIMIT) && (sdiff <= WORD_LIMIT);
        cnt_inc   = r_cnt + 25'd1;
        esc_inc   = r_esc + 25'd1;
        done      = (cnt_inc == i_frame_pixels);

        o_rec            = '0;
        o_rec.done       = done;
        o_rec.base       = r_total;
        n_prev           = r_prev;
        n_esc            = r_esc;
        n_abort          = r_abort;
        n_total          = r_total;
        n_cnt            = cnt_inc;

        if (r_abort) begin
            o_rec.nbytes     = LEN_SHORT;
            o_rec.byte_valid = 1'b0;
            o_rec.aborted    = 1'b1;
        end else begin
            o_rec.byte_valid = 1'b1;
            n_prev           = i_pixel;
            if (fits_byte) begin
                o_rec.nbytes   = LEN_SHORT;
                o_rec.bytes[0] = diff[7:0];
            end else if (fits_word) begin
                o_rec.nbytes   = LEN_MID;
                o_rec.bytes[0] = ESC_BYTE;
                o_rec.bytes[1] = diff[7:0];
                o_rec.bytes[2] = diff[15:8];
            end else begin
                o_rec.nbytes   = LEN_WIDE;
                o_rec.bytes[0] = ESC_BYTE;
                o_rec.bytes[1] = ESC_WORD[7:0];
                o_rec.bytes[2] = ESC_WORD[15:8];
                o_rec.bytes[3] = diff[7:0];
                o_rec.bytes[4] = diff[15:8];
                o_rec.bytes[5] = diff[23:16];
                o_rec.bytes[6] = diff[31:24];
                n_esc          = esc_inc;
                if (esc_inc > (i_frame_pixels >> 2)) begin
                    n_abort = 1'b1;
                end
            end
            o_rec.aborted = n_abort;
            n_total       = r_total + COUNT_W'(o_rec.nbytes);
        end

        if (done) begin
            n_prev  = '0;
            n_cnt   = '0;
            n_esc   = '0;
            n_abort = 1'b0;
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_cnt   <= '0;
            r_esc   <= '0;
            r_abort <= 1'b0;
            r_total <= '0;
        end else if (i_accept) begin
            r_prev  <= n_prev;
            r_cnt   <= n_cnt;
            r_esc   <= n_esc;
            r_abort <= n_abort;
            r_total <= n_total;
        end
    end

endmodule

// ----- design/cbe_serializer.sv -----
// Holds one encoded pixel and sends its bytes one item per cycle through the output
// register while the receiver does not stall. Depends on cbe_pkg.
module cbe_serializer
    import cbe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_pixel_rec         i_rec,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_last_of_pixel,
    output logic               o_frame_done,
    output logic               o_frame_aborted,
    output logic [COUNT_W-1:0] o_byte_count
);

    t_pixel_rec          r_rec;
    logic                r_rec_valid;
    logic [NBYTES_W-1:0] r_idx;
    logic                r_out_valid;
    logic [7:0]          r_byte;
    logic                r_bvalid;
    logic                r_last;
    logic                r_done;
    logic                r_aborted;
    logic [COUNT_W-1:0]  r_count;

    logic out_load;
    logic take;
    logic rec_last;

    always_comb begin
        out_load = !r_out_valid || !i_stall;
        take     = out_load && r_rec_valid;
        rec_last = (r_idx == r_rec.nbytes - 3'd1);
        o_free   = !r_rec_valid || (take && rec_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_rec_valid <= 1'b1;
                r_idx       <= '0;
            end else if (take && rec_last) begin
                r_rec_valid <= 1'b0;
            end else if (take) begin
                r_idx <= r_idx + 3'd1;
            end
            if (out_load) begin
                r_out_valid <= r_rec_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end
        if (take) begin
            r_byte    <= r_rec.bytes[r_idx];
            r_bvalid  <= r_rec.byte_valid;
            r_last    <= rec_last;
            r_done    <= r_rec.done;
            r_aborted <= r_rec.aborted;
            r_count   <= r_rec.byte_valid
                         ? r_rec.base + COUNT_W'(r_idx) + 27'd1
                         : r_rec.base;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bvalid;
    assign o_last_of_pixel = r_last;
    assign o_frame_done    = r_done;
    assign o_frame_aborted = r_aborted;
    assign o_byte_count    = r_count;

endmodule

// ----- design/cbe_checker.sv -----
// Port-level checks for the byte-offset encoder, bound to the top level.
// Depends on cbe_pkg and cbf_byte_offset_encoder.
module cbe_checker
    import cbe_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [7:0]         o_out_byte,
    input logic               o_byte_valid,
    input logic               o_last_of_pixel,
    input logic               o_frame_aborted,
    input logic [COUNT_W-1:0] o_byte_count
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_byte_count))
        else $error("Stalled item changed.");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_last_of_pixel && o_frame_aborted)
        else $error("Empty item is not a lone item of an aborted frame.");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_out_byte == 8'h00)
        else $error("Empty item carries a nonzero byte.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_byte_valid && !o_last_of_pixel
        |=> o_valid && (o_byte_count == COUNT_W'($past(o_byte_count) + 27'd1)))
        else $error("Byte count did not advance by one within a pixel.");

endmodule

bind cbf_byte_offset_encoder cbe_checker u_cbe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_out_byte      (o_out_byte),
    .o_byte_valid    (o_byte_valid),
    .o_last_of_pixel (o_last_of_pixel),
    .o_frame_aborted (o_frame_aborted),
    .o_byte_count    (o_byte_count)
);

// ----- test/tb.sv -----
// Self-checking testbench for cbf_byte_offset_encoder: pixels go in over valid/stall, the
// encoded byte stream is checked against a predictor of the byte-offset scheme.
// Depends on cbe_pkg and the encoder RTL; the frame length is set over the APB port.

typedef struct {
    logic [7:0]                  out_byte;
    logic                        byte_valid;
    logic                        last_of_pixel;
    logic                        frame_done;
    logic                        frame_aborted;
    logic [cbe_pkg::COUNT_W-1:0] byte_count;
} t_encoded_byte;

class encoded_stream_board;
    logic [cbe_pkg::FP_W-1:0]    frame_len;
    logic [31:0]                 last_pixel;
    logic [cbe_pkg::FP_W-1:0]    pixels_seen;
    logic [cbe_pkg::FP_W-1:0]    wide_escapes;
    bit                          aborted;
    logic [cbe_pkg::COUNT_W-1:0] bytes_sent;
    t_encoded_byte               expected_bytes[$];
    int                          errors;

    function new();
        frame_len = cbe_pkg::FRAME_PIXELS_RST;
        errors = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        last_pixel = '0;
        pixels_seen = '0;
        wide_escapes = '0;
        aborted = 1'b0;
        bytes_sent = '0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    function void encode_pixel(logic [31:0] px);
        logic [31:0]   diff;
        logic [31:0]   mag;
        logic [7:0]    seq[7];
        int            n;
        bit            done;
        t_encoded_byte r;
        pixels_seen = pixels_seen + 1'b1;
        done = (pixels_seen == frame_len);
        if (aborted) begin
            r.out_byte = 8'h00;
            r.byte_valid = 1'b0;
            r.last_of_pixel = 1'b1;
            r.frame_done = done;
            r.frame_aborted = 1'b1;
            r.byte_count = bytes_sent;
            expected_bytes.push_back(r);
            if (done)
                clear_frame();
            return;
        end
        diff = px - last_pixel;
        mag = diff[31] ? (32'd0 - diff) : diff;
        if (mag <= $unsigned(cbe_pkg::BYTE_LIMIT)) begin
            seq[0] = diff[7:0];
            n = 1;
        end else if (mag <= $unsigned(cbe_pkg::WORD_LIMIT)) begin
            seq[0] = cbe_pkg::ESC_BYTE;
            seq[1] = diff[7:0];
            seq[2] = diff[15:8];
            n = 3;
        end else begin
            seq[0] = cbe_pkg::ESC_BYTE;
            seq[1] = cbe_pkg::ESC_WORD[7:0];
            seq[2] = cbe_pkg::ESC_WORD[15:8];
            seq[3] = diff[7:0];
            seq[4] = diff[15:8];
            seq[5] = diff[23:16];
            seq[6] = diff[31:24];
            n = 7;
            wide_escapes = wide_escapes + 1'b1;
            if (wide_escapes > (frame_len >> 2))
                aborted = 1'b1;
        end
        last_pixel = px;
        for (int k = 0; k < n; k++) begin
            bytes_sent = bytes_sent + 1'b1;
            r.out_byte = seq[k];
            r.byte_valid = 1'b1;
            r.last_of_pixel = (k == n - 1);
            r.frame_done = done;
            r.frame_aborted = aborted;
            r.byte_count = bytes_sent;
            expected_bytes.push_back(r);
        end
        if (done)
            clear_frame();
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp, act);
            errors++;
        end
    endfunction

    function void compare_byte(t_encoded_byte got);
        t_encoded_byte exp;
        if (expected_bytes.size() == 0) begin
            $error("Output item with no pending expectation: out_byte 0x%0h", got.out_byte);
            errors++;
            return;
        end
        exp = expected_bytes.pop_front();
        check_field("out_byte", exp.out_byte, got.out_byte);
        check_field("byte_valid", exp.byte_valid, got.byte_valid);
        check_field("last_of_pixel", exp.last_of_pixel, got.last_of_pixel);
        check_field("frame_done", exp.frame_done, got.frame_done);
        check_field("frame_aborted", exp.frame_aborted, got.frame_aborted);
        check_field("byte_count", exp.byte_count, got.byte_count);
    endfunction
endclass

module tb
    import cbe_pkg::*;
();

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    localparam logic [APB_AW-1:0] ADDR_FRAME_PIXELS = APB_AW'({REG_FRAME_PIXELS, 2'b00});
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED     = APB_AW'(4);
    localparam int                CYCLE_LIMIT       = 300000;
    localparam int                SETTLE_CYCLES     = 6;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [PIXEL_W-1:0] i_pixel;
    logic               o_valid;
    logic               i_stall;
    logic [7:0]         o_out_byte;
    logic               o_byte_valid;
    logic               o_last_of_pixel;
    logic               o_frame_done;
    logic               o_frame_aborted;
    logic [COUNT_W-1:0] o_byte_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    encoded_stream_board board;
    int                  send_pct;
    int                  stall_pct;
    int                  read_errors;
    int                  cycle_count;

    cbf_byte_offset_encoder u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        t_encoded_byte got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.out_byte = o_out_byte;
            got.byte_valid = o_byte_valid;
            got.last_of_pixel = o_last_of_pixel;
            got.frame_done = o_frame_done;
            got.frame_aborted = o_frame_aborted;
            got.byte_count = o_byte_count;
            board.compare_byte(got);
        end
    end

    task automatic set_idling(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_pct = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_pct = 73;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_pct = 0;
                stall_pct = 73;
            end
            default: begin
                send_pct = 26;
                stall_pct = 26;
            end
        endcase
    endtask

    task automatic send_pixel(logic [31:0] px);
        while ($urandom_range(99) < send_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.encode_pixel(px);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (addr == ADDR_FRAME_PIXELS)
            board.frame_len = data[FP_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] exp);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== exp) begin
            $error("prdata mismatch: expected 0x%0h, actual 0x%0h", exp, prdata);
            read_errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [APB_DW-1:0] value);
        apb_write(ADDR_FRAME_PIXELS, value);
        apb_read(ADDR_FRAME_PIXELS, APB_DW'(value[FP_W-1:0]));
    endtask

    // Differences are drawn from the three encoding classes, with their edges favored.
    function automatic logic [31:0] pick_pixel(logic [31:0] prev, int wide_pct);
        int          roll;
        logic [31:0] step;
        roll = $urandom_range(99);
        if (roll < wide_pct) begin
            case ($urandom_range(3))
                0: return $urandom;
                1: step = 32'h8000_0000;
                2: step = 32'($urandom_range(32'h7FFF_FFFF, 32768));
                default: step = 32'($urandom_range(40000, 32768));
            endcase
        end else if (roll < wide_pct + 20) begin
            case ($urandom_range(3))
                0: step = 32'd128;
                1: step = 32'd32767;
                default: step = 32'($urandom_range(32767, 128));
            endcase
        end else begin
            step = ($urandom_range(3) == 0) ? 32'd127 : 32'($urandom_range(127, 0));
        end
        if ($urandom_range(1))
            step = 32'd0 - step;
        return prev + step;
    endfunction

    task automatic send_random(t_idle_mode mode, int count, int wide_pct);
        set_idling(mode);
        repeat (count)
            send_pixel(pick_pixel(board.last_pixel, wide_pct));
    endtask

    // A frame still open is closed by moving its end to the next pixel.
    task automatic close_frame();
        wait_idle();
        if (board.pixels_seen != 0) begin
            set_idling(IDLE_NONE);
            configure(APB_DW'(board.pixels_seen) + 1);
            send_pixel($urandom);
            wait_idle();
        end
    endtask

    initial begin
        logic [31:0] edge_pixels[$];
        board = new();
        send_pct = 0;
        stall_pct = 0;
        read_errors = 0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pixel = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_read(ADDR_FRAME_PIXELS, APB_DW'(FRAME_PIXELS_RST));
        edge_pixels = '{32'd0, 32'd127, 32'd0, 32'd128, 32'd0, 32'd32767, 32'd0,
                        32'd32768, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF81};
        foreach (edge_pixels[k])
            send_pixel(edge_pixels[k]);
        send_random(IDLE_SENDER, 10, 15);
        close_frame();

        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        apb_read(ADDR_FRAME_PIXELS, APB_DW'(board.frame_len));

        configure(32'd1);
        send_pixel(32'h1234_5678);
        send_pixel(32'd5);
        send_random(IDLE_RECEIVER, 20, 30);
        close_frame();

        configure(32'd4);
        edge_pixels = '{32'h4000_0000, 32'd0, 32'd5, 32'd6};
        foreach (edge_pixels[k])
            send_pixel(edge_pixels[k]);
        wait_idle();
        send_random(IDLE_BOTH, 20, 35);
        close_frame();

        configure(32'hFE00_0007);
        send_random(IDLE_SENDER, 20, 25);
        close_frame();

        configure(32'd0);
        send_random(IDLE_NONE, 15, 20);
        close_frame();

        configure(32'd16777216);
        send_random(IDLE_BOTH, 15, 40);
        send_random(IDLE_RECEIVER, 5, 20);
        close_frame();

        if (board.errors == 0 && read_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- cbf_byte_offset_encoder.f -----
design/cbe_pkg.sv
design/cbe_encoder.sv
design/cbe_serializer.sv
design/cbf_byte_offset_encoder.sv
design/cbe_checker.sv
test/tb.sv
